// ----- hdl/fdc_pkg.sv -----
`default_nettype none
package fdc_pkg;

    // start-of-frame marker byte
    localparam logic [7:0] START_MARK = 8'd126;

    // parser phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_SIZE = 5'b00010,
        PH_SEQT = 5'b00100,
        PH_CHK  = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    // one result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       frame_done;
        logic [6:0] frame_length;
        logic [4:0] seq_number;
        logic [3:0] frame_type;
        logic       checksum_ok;
    } t_result;

endpackage
`default_nettype wire

// ----- hdl/fdc_parser.sv -----
`default_nettype none
module fdc_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output fdc_pkg::t_result     o_result,
    output logic                 o_result_valid
);

    fdc_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [6:0] r_length, n_length;
    logic [6:0] r_left, n_left;
    logic [4:0] r_seq, n_seq;
    logic [3:0] r_type, n_type;
    logic [7:0] sum_add;

    assign sum_add = r_sum + i_byte;

    // per-byte parser step
    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_length = r_length;
        n_left   = r_left;
        n_seq    = r_seq;
        n_type   = r_type;
        o_result_valid         = 1'b0;
        o_result.data_byte     = 8'd0;
        o_result.data_valid    = 1'b0;
        o_result.frame_done    = 1'b0;
        o_result.frame_length  = r_length;
        o_result.seq_number    = r_seq;
        o_result.frame_type    = r_type;
        o_result.checksum_ok   = 1'b0;
        case (r_phase)
            fdc_pkg::PH_SIZE: begin
                n_sum    = i_byte;
                n_length = i_byte[7:1];
                n_left   = i_byte[7:1];
                n_seq    = {i_byte[0], 4'd0};
                n_phase  = fdc_pkg::PH_SEQT;
            end
            fdc_pkg::PH_SEQT: begin
                // high nibble is the low part of the sequence, low nibble the type
                n_sum   = sum_add;
                n_seq   = {r_seq[4], i_byte[7:4]};
                n_type  = i_byte[3:0];
                n_phase = fdc_pkg::PH_CHK;
            end
            fdc_pkg::PH_CHK: begin
                n_sum = sum_add;
                if (r_left == 7'd0) begin
                    // empty payload completes on the checksum byte
                    n_phase                = fdc_pkg::PH_HUNT;
                    o_result_valid         = 1'b1;
                    o_result.frame_done    = 1'b1;
                    o_result.checksum_ok   = (sum_add == 8'd0);
                end else begin
                    n_phase = fdc_pkg::PH_DATA;
                end
            end
            fdc_pkg::PH_DATA: begin
                n_sum  = sum_add;
                n_left = r_left - 7'd1;
                o_result_valid       = 1'b1;
                o_result.data_byte   = i_byte;
                o_result.data_valid  = 1'b1;
                if (r_left == 7'd1) begin
                    n_phase              = fdc_pkg::PH_HUNT;
                    o_result.frame_done  = 1'b1;
                    o_result.checksum_ok = (sum_add == 8'd0);
                end
            end
            default: begin
                // hunting, stray bytes dropped
                n_phase = fdc_pkg::PH_HUNT;
                if (i_byte == fdc_pkg::START_MARK) begin
                    n_sum   = 8'd0;
                    n_phase = fdc_pkg::PH_SIZE;
                end
            end
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= fdc_pkg::PH_HUNT;
            r_sum    <= 8'd0;
            r_length <= 7'd0;
            r_left   <= 7'd0;
            r_seq    <= 5'd0;
            r_type   <= 4'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_length <= n_length;
            r_left   <= n_left;
            r_seq    <= n_seq;
            r_type   <= n_type;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/fdc_outbuf.sv -----
`default_nettype none
module fdc_outbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fdc_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output fdc_pkg::t_result      o_data,
    input  wire logic             i_stall
);

    logic             r_main_valid;
    logic             r_skid_valid;
    fdc_pkg::t_result r_main;
    fdc_pkg::t_result r_skid;
    logic             out_take;

    assign out_take = r_main_valid && !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_data   = r_main;

    // control: main holds the presented transfer, skid catches one more
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || out_take) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_main_valid || out_take) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/frame_decode_checksum_verify.sv -----
// Receive-side byte deframer with an 8-bit additive checksum.
// Input channel: i_valid / o_stall carry one link byte per transfer on i_rx_byte.
// Bytes are dropped until the start marker arrives; then come a size byte,
// a sequence/type byte, a checksum byte and the payload bytes.
// Output channel: o_valid / i_stall carry one result per payload byte, or one
// result on the checksum byte of an empty frame; header bytes give none.
// Frame fields (length, sequence, type) ride on every result; o_checksum_ok
// is set with o_frame_done when the byte sum after the marker is zero.
// Throughput: one byte per cycle while o_stall is low; the parser state advances on each accepted byte.
// Each result is registered in the output buffer before it is shown; a receiver stall can hold it in the skid entry.
// A two-entry output register decouples the sides: while the receiver stalls
// one more result is absorbed, then o_stall rises until the receiver drains.
// Reset (synchronous, active low) returns the parser to hunting, clears the
// checksum and held fields and empties the output register.
`default_nettype none
module frame_decode_checksum_verify (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_data_byte,
    output logic            o_data_valid,
    output logic            o_frame_done,
    output logic [6:0]      o_frame_length,
    output logic [4:0]      o_seq_number,
    output logic [3:0]      o_frame_type,
    output logic            o_checksum_ok
);

    logic             in_take;
    logic             res_valid;
    logic             buf_full;
    fdc_pkg::t_result res;
    fdc_pkg::t_result out_res;

    assign o_stall = buf_full;
    assign in_take = i_valid && !buf_full;

    // byte parser
    fdc_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_take),
        .i_byte         (i_rx_byte),
        .o_result       (res),
        .o_result_valid (res_valid)
    );

    // output register with skid
    fdc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_take && res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_res),
        .i_stall (i_stall)
    );

    assign o_data_byte    = out_res.data_byte;
    assign o_data_valid   = out_res.data_valid;
    assign o_frame_done   = out_res.frame_done;
    assign o_frame_length = out_res.frame_length;
    assign o_seq_number   = out_res.seq_number;
    assign o_frame_type   = out_res.frame_type;
    assign o_checksum_ok  = out_res.checksum_ok;

endmodule
`default_nettype wire
